/* rtl/assert_macros.svh */
// Assertion helpers used by u8d_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define U8D_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define U8D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and byte class constants for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int ByteWidth  = 8;
   localparam int CodeWidth  = 21;
   localparam int StatWidth  = 2;
   localparam int LenWidth   = 3;
   localparam int CountWidth = 2;

   // Byte class masks and patterns
   localparam logic [7:0] ContMask  = 8'hc0;
   localparam logic [7:0] ContPat   = 8'h80;
   localparam logic [7:0] Lead2Mask = 8'he0;
   localparam logic [7:0] Lead2Pat  = 8'hc0;
   localparam logic [7:0] Lead3Mask = 8'hf0;
   localparam logic [7:0] Lead3Pat  = 8'he0;
   localparam logic [7:0] Lead4Mask = 8'hf8;
   localparam logic [7:0] Lead4Pat  = 8'hf0;
   localparam logic [7:0] Pay2Mask  = 8'h1f;
   localparam logic [7:0] Pay3Mask  = 8'h0f;
   localparam logic [7:0] Pay4Mask  = 8'h07;
   localparam logic [7:0] ContPayMask = 8'h3f;

   typedef enum logic [StatWidth-1:0] {
      ST_OK      = 2'd0,
      ST_STRAY   = 2'd1,
      ST_TRUNC   = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef struct packed {
      logic [CodeWidth-1:0] code_point;
      status_type           status;
      logic [LenWidth-1:0]  seq_length;
   } result_type;

endpackage

/* rtl/utf8_byte_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Decodes a UTF-8 byte stream, one byte word in, zero or one code point out.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one raw text byte per word (req_valid / req_stall).
//   rsp channel: code point, status and nominal sequence length per word
//   (rsp_valid / rsp_stall). Status: ok, stray continuation, truncated
//   sequence (code point is the lead byte), invalid lead (code point 0).
//   A lead byte, a byte that only continues an open sequence, or one that is
//   dropped after a truncation, produces no rsp word.
//   Throughput: one byte per cycle while rsp is not stalled, set by the single
//   decode step between the input register and the result register.
//   Path: an accepted byte is held in the input register, decoded, and its
//   result is loaded into the result register that drives rsp.
//   Receiver stall: the result register holds; the input register takes one
//   more byte if it is empty, then req_stall rises until the result leaves.
//   Reset: clears the valid flags of both registers and all decode state; no sequence is open.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [u8d_pkg::ByteWidth-1:0]  req_in_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [u8d_pkg::CodeWidth-1:0]  rsp_code_point,
   output logic [u8d_pkg::StatWidth-1:0]  rsp_status,
   output logic [u8d_pkg::LenWidth-1:0]   rsp_seq_length
);

   logic                          word_valid;
   logic [u8d_pkg::ByteWidth-1:0] word_byte;
   logic                          out_open;
   logic                          step;
   logic                          res_valid;
   u8d_pkg::result_type           res;

   assign step = word_valid && out_open;

   u8d_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .take        (out_open),
      .word_valid  (word_valid),
      .word_byte   (word_byte)
   );

   u8d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (word_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   u8d_out_reg u_out_reg (
      .clock          (clock),
      .reset          (reset),
      .new_valid      (step && res_valid),
      .new_res        (res),
      .open           (out_open),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_status     (rsp_status),
      .rsp_seq_length (rsp_seq_length)
   );

endmodule

/* rtl/u8d_in_reg.sv */
// ----------------------------------------------------------------------------
// u8d_in_reg
// Input register: holds one byte word until the decode stage takes it.
// ----------------------------------------------------------------------------
module u8d_in_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [u8d_pkg::ByteWidth-1:0]  req_in_byte,
   output logic                           req_stall,
   input  logic                           take,
   output logic                           word_valid,
   output logic [u8d_pkg::ByteWidth-1:0]  word_byte
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [u8d_pkg::ByteWidth-1:0] byte_ff;
   logic                          load;

   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         byte_ff <= req_in_byte;
      end
   end

   assign word_valid = valid_ff;
   assign word_byte  = byte_ff;

endmodule

/* rtl/u8d_core.sv */
// ----------------------------------------------------------------------------
// u8d_core
// Decode state and the per-byte step: accumulate payload bits, count
// pending and discarded bytes, classify each byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8d_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [u8d_pkg::ByteWidth-1:0] in_byte,
   output logic                          res_valid,
   output u8d_pkg::result_type           res
);

   logic [u8d_pkg::CountWidth-1:0] bytes_pending_ff, bytes_pending_in;
   logic [u8d_pkg::CountWidth-1:0] bytes_to_discard_ff, bytes_to_discard_in;
   logic [u8d_pkg::CodeWidth-1:0]  accumulator_ff, accumulator_in;
   logic [u8d_pkg::ByteWidth-1:0]  lead_value_ff, lead_value_in;
   logic [u8d_pkg::LenWidth-1:0]   nominal_length_ff, nominal_length_in;

   logic                           is_cont;
   logic [u8d_pkg::CodeWidth-1:0]  cont_bits;
   logic [u8d_pkg::CodeWidth-1:0]  acc_sum;

   assign is_cont = (in_byte & u8d_pkg::ContMask) == u8d_pkg::ContPat;

   // Place the six payload bits by how many words are still expected.
   always_comb begin
      cont_bits = '0;
      case (bytes_pending_ff)
         2'd2:    cont_bits = {9'd0, in_byte[5:0], 6'd0};
         2'd3:    cont_bits = {3'd0, in_byte[5:0], 12'd0};
         default: cont_bits = {15'd0, in_byte[5:0]};
      endcase
   end

   assign acc_sum = accumulator_ff + cont_bits;

   always_comb begin
      bytes_pending_in    = bytes_pending_ff;
      bytes_to_discard_in = bytes_to_discard_ff;
      accumulator_in      = accumulator_ff;
      lead_value_in       = lead_value_ff;
      nominal_length_in   = nominal_length_ff;
      res_valid           = 1'b0;
      res.code_point      = '0;
      res.status          = u8d_pkg::ST_OK;
      res.seq_length      = '0;

      if (bytes_to_discard_ff != '0) begin
         bytes_to_discard_in = bytes_to_discard_ff - 2'd1;
      end else if (bytes_pending_ff != '0) begin
         if (is_cont) begin
            accumulator_in   = acc_sum;
            bytes_pending_in = bytes_pending_ff - 2'd1;
            if (bytes_pending_ff == 2'd1) begin
               res_valid      = 1'b1;
               res.code_point = acc_sum;
               res.seq_length = nominal_length_ff;
            end
         end else begin
            // Sequence cut short: drop this word and the rest of the length.
            bytes_to_discard_in = bytes_pending_ff - 2'd1;
            bytes_pending_in    = '0;
            res_valid           = 1'b1;
            res.code_point      = {13'd0, lead_value_ff};
            res.status          = u8d_pkg::ST_TRUNC;
            res.seq_length      = nominal_length_ff;
         end
      end else if (!in_byte[7]) begin
         res_valid      = 1'b1;
         res.code_point = {13'd0, in_byte};
         res.seq_length = 3'd1;
      end else if (is_cont) begin
         res_valid      = 1'b1;
         res.code_point = {13'd0, in_byte};
         res.status     = u8d_pkg::ST_STRAY;
         res.seq_length = 3'd1;
      end else if ((in_byte & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Pat) begin
         accumulator_in    = {10'd0, in_byte[4:0], 6'd0};
         bytes_pending_in  = 2'd1;
         nominal_length_in = 3'd2;
         lead_value_in     = in_byte;
      end else if ((in_byte & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Pat) begin
         accumulator_in    = {5'd0, in_byte[3:0], 12'd0};
         bytes_pending_in  = 2'd2;
         nominal_length_in = 3'd3;
         lead_value_in     = in_byte;
      end else if ((in_byte & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Pat) begin
         accumulator_in    = {in_byte[2:0], 18'd0};
         bytes_pending_in  = 2'd3;
         nominal_length_in = 3'd4;
         lead_value_in     = in_byte;
      end else begin
         res_valid  = 1'b1;
         res.status = u8d_pkg::ST_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff    <= '0;
         bytes_to_discard_ff <= '0;
         accumulator_ff      <= '0;
         lead_value_ff       <= '0;
         nominal_length_ff   <= '0;
      end else if (step) begin
         bytes_pending_ff    <= bytes_pending_in;
         bytes_to_discard_ff <= bytes_to_discard_in;
         accumulator_ff      <= accumulator_in;
         lead_value_ff       <= lead_value_in;
         nominal_length_ff   <= nominal_length_in;
      end
   end

   `U8D_ASSERT(a_pend_disc_excl, clock, reset,
      (bytes_pending_ff == '0 || bytes_to_discard_ff == '0), "pending and discard both open")
   `U8D_ASSERT(a_open_has_len, clock, reset,
      (bytes_pending_ff == '0 || nominal_length_ff >= 3'd2), "open sequence without length")
   `U8D_ASSERT(a_trunc_closes, clock, reset,
      (step && res_valid && res.status == u8d_pkg::ST_TRUNC |=> bytes_pending_ff == '0), "truncation left sequence open")
   `U8D_ASSERT(a_invalid_zero, clock, reset,
      (res_valid && res.status == u8d_pkg::ST_INVALID |-> res.code_point == '0 && res.seq_length == '0), "invalid lead with payload")

endmodule

/* rtl/u8d_out_reg.sv */
// ----------------------------------------------------------------------------
// u8d_out_reg
// Result register: holds one decoded word until the receiver takes it.
// ----------------------------------------------------------------------------
module u8d_out_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           new_valid,
   input  u8d_pkg::result_type            new_res,
   output logic                           open,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [u8d_pkg::CodeWidth-1:0]  rsp_code_point,
   output logic [u8d_pkg::StatWidth-1:0]  rsp_status,
   output logic [u8d_pkg::LenWidth-1:0]   rsp_seq_length
);

   logic                valid_ff;
   logic                valid_in;
   u8d_pkg::result_type res_ff;

   // Register may load when empty or when its word leaves this cycle.
   assign open     = !valid_ff || !rsp_stall;
   assign valid_in = open ? new_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (open && new_valid) begin
         res_ff <= new_res;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code_point = res_ff.code_point;
   assign rsp_status     = res_ff.status;
   assign rsp_seq_length = res_ff.seq_length;

endmodule
